FILE: src/ipd_pkg.sv
package ipd_pkg;

  localparam int HdrLen = 5;
  localparam int MaxLenW = 11;
  localparam int LenAccW = 12;
  localparam logic [MaxLenW-1:0] MaxLenReset = 11'd255;
  localparam logic [7:0] LinkSat = 8'd255;
  localparam logic [LenAccW-1:0] LenSat = 12'd4095;
  localparam int QueueDepth = 2;

  localparam logic [7:0] ChPlus = 8'h2B;
  localparam logic [7:0] ChComma = 8'h2C;
  localparam logic [7:0] ChColon = 8'h3A;
  localparam logic [7:0] ChZero = 8'h30;
  localparam logic [7:0] ChNine = 8'h39;

  localparam logic KindData = 1'b0;
  localparam logic KindReject = 1'b1;

  localparam logic CfgIdxMaxLen = 1'b0;

  typedef enum logic [3:0] {
    PH_HUNT = 4'b0001,
    PH_LINK = 4'b0010,
    PH_LEN  = 4'b0100,
    PH_DATA = 4'b1000
  } ipd_phase_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] data;
    logic [7:0] link;
    logic       last;
  } ipd_evt_t;

  typedef struct packed {
    logic full;
    logic empty;
  } ipd_q_stat_t;

  function automatic logic [7:0] hdr_char(input logic [2:0] idx);
    logic [7:0] c;
    unique case (idx)
      3'd0: c = 8'h2B;
      3'd1: c = 8'h49;
      3'd2: c = 8'h50;
      3'd3: c = 8'h44;
      3'd4: c = 8'h2C;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

FILE: src/ipd_front.sv
module ipd_front
  import ipd_pkg::*;
#(
  parameter int MAX_LEN_W = MaxLenW
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 take,
  input  logic [7:0]           rx_byte,
  input  logic [MAX_LEN_W-1:0] max_len,
  output logic                 evt_valid,
  output ipd_evt_t             evt
);

  ipd_phase_t           phase_r, phase_nxt;
  logic [2:0]           match_r, match_nxt;
  logic [7:0]           link_r, link_nxt;
  logic [LenAccW-1:0]   len_r, len_nxt;
  logic                 seen_r, seen_nxt;
  logic [MAX_LEN_W-1:0] left_r, left_nxt;

  logic                 is_digit;
  logic                 is_plus;
  logic [11:0]          link_mac;
  logic [15:0]          len_mac;
  logic [MAX_LEN_W-1:0] left_dec;
  logic                 len_bad;

  assign is_digit = (rx_byte >= ChZero) && (rx_byte <= ChNine);
  assign is_plus  = (rx_byte == ChPlus);
  assign link_mac = ({4'b0, link_r} << 3) + ({4'b0, link_r} << 1) + {8'b0, rx_byte[3:0]};
  assign len_mac  = ({4'b0, len_r} << 3) + ({4'b0, len_r} << 1) + {12'b0, rx_byte[3:0]};
  assign left_dec = left_r - 1'b1;
  assign len_bad  = (len_r == '0) || (len_r > LenAccW'(max_len));

  always_comb begin
    phase_nxt = phase_r;
    match_nxt = match_r;
    link_nxt  = link_r;
    len_nxt   = len_r;
    seen_nxt  = seen_r;
    left_nxt  = left_r;
    evt_valid = 1'b0;
    evt.kind  = KindData;
    evt.data  = rx_byte;
    evt.link  = link_r;
    evt.last  = 1'b0;
    if (take) begin
      unique case (phase_r)
        PH_HUNT: begin
          if ((32'(match_r) < HdrLen) && (rx_byte == hdr_char(match_r))) begin
            if (32'(match_r) == HdrLen - 1) begin
              phase_nxt = PH_LINK;
              match_nxt = '0;
              link_nxt  = '0;
              len_nxt   = '0;
              seen_nxt  = 1'b0;
            end else begin
              match_nxt = match_r + 3'd1;
            end
          end else begin
            match_nxt = {2'b0, is_plus};
          end
        end
        PH_LINK: begin
          if (is_digit) begin
            link_nxt = (link_mac > {4'b0, LinkSat}) ? LinkSat : link_mac[7:0];
            seen_nxt = 1'b1;
          end else if ((rx_byte == ChComma) && seen_r) begin
            phase_nxt = PH_LEN;
            seen_nxt  = 1'b0;
            len_nxt   = '0;
          end else begin
            phase_nxt = PH_HUNT;
            match_nxt = {2'b0, is_plus};
            link_nxt  = '0;
            len_nxt   = '0;
            seen_nxt  = 1'b0;
            left_nxt  = '0;
          end
        end
        PH_LEN: begin
          if (is_digit) begin
            len_nxt  = (len_mac > {4'b0, LenSat}) ? LenSat : len_mac[LenAccW-1:0];
            seen_nxt = 1'b1;
          end else if ((rx_byte == ChColon) && seen_r && !len_bad) begin
            phase_nxt = PH_DATA;
            left_nxt  = len_r[MAX_LEN_W-1:0];
            seen_nxt  = 1'b0;
          end else begin
            if ((rx_byte == ChColon) && seen_r) begin
              evt_valid = 1'b1;
              evt.kind  = KindReject;
              evt.last  = 1'b1;
            end
            phase_nxt = PH_HUNT;
            match_nxt = (rx_byte == ChColon) ? 3'd0 : {2'b0, is_plus};
            link_nxt  = '0;
            len_nxt   = '0;
            seen_nxt  = 1'b0;
            left_nxt  = '0;
          end
        end
        PH_DATA: begin
          if (left_r != '0) begin
            evt_valid = 1'b1;
            evt.last  = (left_dec == '0);
            left_nxt  = left_dec;
          end
          if ((left_r == '0) || (left_dec == '0)) begin
            phase_nxt = PH_HUNT;
            match_nxt = '0;
            link_nxt  = '0;
            len_nxt   = '0;
            seen_nxt  = 1'b0;
            left_nxt  = '0;
          end
        end
        default: phase_nxt = PH_HUNT;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
      match_r <= '0;
      link_r  <= '0;
      len_r   <= '0;
      seen_r  <= 1'b0;
      left_r  <= '0;
    end else begin
      phase_r <= phase_nxt;
      match_r <= match_nxt;
      link_r  <= link_nxt;
      len_r   <= len_nxt;
      seen_r  <= seen_nxt;
      left_r  <= left_nxt;
    end
  end

endmodule

FILE: src/ipd_queue.sv
module ipd_queue
  import ipd_pkg::*;
#(
  parameter int DEPTH = QueueDepth
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  ipd_evt_t    push_evt,
  input  logic        pop,
  output ipd_evt_t    head_evt,
  output ipd_q_stat_t stat
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  ipd_evt_t        mem_r [DEPTH];
  logic [AW-1:0]   wr_r, wr_nxt;
  logic [AW-1:0]   rd_r, rd_nxt;
  logic [AW:0]     cnt_r, cnt_nxt;
  logic            do_push;
  logic            do_pop;

  assign stat.full  = (cnt_r == (AW+1)'(DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign head_evt   = mem_r[rd_r];

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (do_push) begin
      wr_nxt = (wr_r == AW'(DEPTH - 1)) ? '0 : wr_r + 1'b1;
    end
    if (do_pop) begin
      rd_nxt = (rd_r == AW'(DEPTH - 1)) ? '0 : rd_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_r] <= push_evt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

FILE: src/ipd_back.sv
module ipd_back
  import ipd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  ipd_q_stat_t q_stat,
  input  ipd_evt_t    head_evt,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_kind,
  output logic [7:0]  out_payload_byte,
  output logic [7:0]  out_link_number,
  output logic        out_is_last
);

  logic       valid_r, valid_nxt;
  logic       kind_r;
  logic [7:0] byte_r;
  logic [7:0] link_r;
  logic       last_r;
  logic       load;

  assign load      = !q_stat.empty && (!valid_r || out_ready);
  assign pop       = load;
  assign valid_nxt = load ? 1'b1 : (out_ready ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      kind_r <= head_evt.kind;
      byte_r <= (head_evt.kind == KindReject) ? 8'h00 : head_evt.data;
      link_r <= head_evt.link;
      last_r <= head_evt.last;
    end
  end

  assign out_valid        = valid_r;
  assign out_kind         = kind_r;
  assign out_payload_byte = byte_r;
  assign out_link_number  = link_r;
  assign out_is_last      = last_r;

endmodule

FILE: src/ipd_payload_deframer_unit.sv
// channel | direction | ports                                   | accepted when
// input   | in        | in_valid, in_ready, in_rx_byte          | in_valid && in_ready
// result  | out       | out_valid, out_ready, out_kind,          | out_valid && out_ready
//         |           | out_payload_byte, out_link_number,      |
//         |           | out_is_last                             |
// config  | in        | psel, penable, pwrite, paddr, pwdata,   | psel && penable && pwrite
//         |           | prdata, pready                          |
//
// One byte per cycle while in_ready is set; the parser state updates in the cycle the byte is taken.
// out_valid rises once a byte that yields an item has passed through the queue and then
// the output register, which presents the item.
// Reset is synchronous and clears parser, queue pointers and output valid; max length resets to 255.
// in_ready drops only when the two-entry queue is full, i.e. after out_ready stays low.
module ipd_payload_deframer_unit
  import ipd_pkg::*;
#(
  parameter int MAX_LEN_W = MaxLenW,
  parameter int Q_DEPTH   = QueueDepth
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_kind,
  output logic [7:0]  out_payload_byte,
  output logic [7:0]  out_link_number,
  output logic        out_is_last,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [MAX_LEN_W-1:0] max_len_r;
  logic                 cfg_wr;
  logic                 take;
  logic                 evt_valid;
  ipd_evt_t             evt;
  ipd_evt_t             head_evt;
  ipd_q_stat_t          q_stat;
  logic                 pop;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == CfgIdxMaxLen) ? 32'(max_len_r) : 32'h0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= MAX_LEN_W'(MaxLenReset);
    end else if (cfg_wr && (paddr[2] == CfgIdxMaxLen)) begin
      max_len_r <= pwdata[MAX_LEN_W-1:0];
    end
  end

  assign in_ready = !q_stat.full;
  assign take     = in_valid && in_ready;

  ipd_front #(.MAX_LEN_W(MAX_LEN_W)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (take),
    .rx_byte   (in_rx_byte),
    .max_len   (max_len_r),
    .evt_valid (evt_valid),
    .evt       (evt)
  );

  ipd_queue #(.DEPTH(Q_DEPTH)) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (evt_valid),
    .push_evt (evt),
    .pop      (pop),
    .head_evt (head_evt),
    .stat     (q_stat)
  );

  ipd_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_stat           (q_stat),
    .head_evt         (head_evt),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_kind         (out_kind),
    .out_payload_byte (out_payload_byte),
    .out_link_number  (out_link_number),
    .out_is_last      (out_is_last)
  );

  a_evt_from_take: assert property (@(posedge clk) disable iff (!rst_n)
    evt_valid |-> take)
    else $error("result produced without an accepted item");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

  a_reject_form: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_kind == KindReject)) |-> ((out_payload_byte == 8'h00) && out_is_last))
    else $error("malformed reject item");

  a_cfg_write: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_wr && (paddr[2] == CfgIdxMaxLen)) |=> (max_len_r == $past(pwdata[MAX_LEN_W-1:0])))
    else $error("max length write lost");

endmodule

FILE: test/ipd_payload_deframer_unit_tb.sv
module ipd_payload_deframer_unit_tb;
  import ipd_pkg::*;

  localparam logic [2:0] AddrMaxLen = 3'd0;
  localparam logic [2:0] AddrSpare = 3'd4;
  localparam string HdrText = "+IPD,";
  localparam string HdrLike = "+IPD,:0123456789";
  localparam int StallLimit = 1000;
  localparam int PhaseItems = 150;

  typedef enum logic [1:0] {
    RowText,
    RowByte,
    RowCfg
  } row_op_t;

  typedef struct packed {
    row_op_t    op;
    logic [7:0] b;
    logic       fixed;
    ipd_evt_t   evt;
    logic [2:0] addr;
    logic [31:0] wdata;
  } dir_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_rx_byte;
  logic        out_valid;
  logic        out_ready;
  logic        out_kind;
  logic [7:0]  out_payload_byte;
  logic [7:0]  out_link_number;
  logic        out_is_last;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  ipd_phase_t        ph;
  logic [2:0]        match_pos;
  logic [7:0]        link_acc;
  logic [LenAccW-1:0] len_acc;
  logic              digit_seen;
  logic [10:0]       left_cnt;
  logic [10:0]       max_len;

  ipd_evt_t pending_outputs[$];
  dir_row_t dir_rows[$];
  string    dir_texts[$];
  ipd_evt_t head;
  bit       calm;
  int       errors;
  int       n_items;
  int       n_results;
  int       n_rejects;
  int       n_writes;
  int       idle_cycles;

  ipd_payload_deframer_unit dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_kind         (out_kind),
    .out_payload_byte (out_payload_byte),
    .out_link_number  (out_link_number),
    .out_is_last      (out_is_last),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void drop_header(input logic [7:0] b);
    ph = PH_HUNT;
    match_pos = (b == ChPlus) ? 3'd1 : 3'd0;
    link_acc = '0;
    len_acc = '0;
    digit_seen = 1'b0;
    left_cnt = '0;
  endfunction

  function automatic bit deframe_byte(input logic [7:0] b, output ipd_evt_t evt);
    bit is_dig;
    int v;
    bit got;
    got = 1'b0;
    evt = '0;
    is_dig = (b >= ChZero) && (b <= ChNine);
    case (ph)
      PH_HUNT: begin
        if (b == HdrText[match_pos]) begin
          if (match_pos == HdrLen - 1) begin
            ph = PH_LINK;
            match_pos = '0;
            link_acc = '0;
            len_acc = '0;
            digit_seen = 1'b0;
          end else begin
            match_pos = match_pos + 3'd1;
          end
        end else begin
          match_pos = (b == ChPlus) ? 3'd1 : 3'd0;
        end
      end
      PH_LINK: begin
        if (is_dig) begin
          v = int'(link_acc) * 10 + int'(b - ChZero);
          link_acc = (v > 255) ? LinkSat : v[7:0];
          digit_seen = 1'b1;
        end else if (b == ChComma && digit_seen) begin
          ph = PH_LEN;
          digit_seen = 1'b0;
          len_acc = '0;
        end else begin
          drop_header(b);
        end
      end
      PH_LEN: begin
        if (is_dig) begin
          v = int'(len_acc) * 10 + int'(b - ChZero);
          len_acc = (v > 4095) ? LenSat : v[LenAccW-1:0];
          digit_seen = 1'b1;
        end else if (b == ChColon && digit_seen) begin
          if (len_acc == 0 || len_acc > {1'b0, max_len}) begin
            evt = '{kind: KindReject, data: 8'h00, link: link_acc, last: 1'b1};
            got = 1'b1;
            drop_header(8'h00);
          end else begin
            ph = PH_DATA;
            left_cnt = len_acc[10:0];
            digit_seen = 1'b0;
          end
        end else begin
          drop_header(b);
        end
      end
      default: begin
        if (left_cnt == 0) begin
          drop_header(8'h00);
        end else begin
          left_cnt = left_cnt - 11'd1;
          evt = '{kind: KindData, data: b, link: link_acc, last: left_cnt == 0};
          got = 1'b1;
          if (left_cnt == 0) drop_header(8'h00);
        end
      end
    endcase
    return got;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  function automatic void add_text(input string s);
    dir_rows.push_back('{op: RowText, b: 8'h00, fixed: 1'b0, evt: '0, addr: '0, wdata: '0});
    dir_texts.push_back(s);
  endfunction

  function automatic void add_byte(input logic [7:0] b, input bit fixed, input ipd_evt_t evt);
    dir_rows.push_back('{op: RowByte, b: b, fixed: fixed, evt: evt, addr: '0, wdata: '0});
    dir_texts.push_back("");
  endfunction

  function automatic void add_cfg(input logic [2:0] addr, input logic [31:0] value);
    dir_rows.push_back('{op: RowCfg, b: 8'h00, fixed: 1'b0, evt: '0, addr: addr, wdata: value});
    dir_texts.push_back("");
  endfunction

  task automatic push_rx(input logic [7:0] b, input bit fixed, input ipd_evt_t typed);
    int gap;
    ipd_evt_t pred;
    bit got;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_rx_byte = b;
    do @(posedge clk); while (!in_ready);
    got = deframe_byte(b, pred);
    if (fixed) pending_outputs.push_back(typed);
    else if (got) pending_outputs.push_back(pred);
    n_items++;
  endtask

  task automatic send_text(input string s);
    for (int k = 0; k < s.len(); k++) push_rx(s[k], 1'b0, '0);
  endtask

  task automatic write_reg(input logic [2:0] addr, input logic [31:0] value);
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_outputs.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    psel = 1'b1;
    pwrite = 1'b1;
    penable = 1'b0;
    paddr = addr;
    pwdata = value;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    if (addr == AddrMaxLen) max_len = value[10:0];
    n_writes++;
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  function automatic logic [7:0] pick_stray(input logic [7:0] field_end);
    logic [7:0] s;
    if ($urandom_range(0, 9) < 3) return ChPlus;
    do s = 8'($urandom_range(0, 255));
    while ((s >= ChZero && s <= ChNine) || s == field_end);
    return s;
  endfunction

  function automatic string pick_link_text();
    int r;
    r = $urandom_range(0, 9);
    if (r < 5) return $sformatf("%0d", $urandom_range(0, 9));
    if (r < 8) return $sformatf("%0d", $urandom_range(0, 255));
    if (r < 9) return $sformatf("%0d", $urandom_range(256, 99999));
    return $sformatf("%03d", $urandom_range(0, 99));
  endfunction

  task automatic send_segment();
    int r;
    int len;
    int small_max;
    string lt;
    string nt;
    logic [7:0] pb;
    r = $urandom_range(0, 99);
    lt = pick_link_text();
    small_max = (max_len < 8) ? int'(max_len) : 8;
    if (r < 70) begin
      r = $urandom_range(0, 99);
      if (r < 72) len = $urandom_range(1, small_max);
      else if (r < 80) len = 0;
      else if (r < 88) len = int'(max_len) + $urandom_range(1, 20);
      else if (r < 93) len = (max_len <= 64) ? int'(max_len) : $urandom_range(1, 32);
      else len = $urandom_range(4096, 99999);
      nt = (len == 0 && $urandom_range(0, 1) == 1) ? "00" : $sformatf("%0d", len);
      send_text({HdrText, lt, ",", nt, ":"});
      if (len >= 1 && len <= int'(max_len)) begin
        for (int k = 0; k < len; k++) begin
          if ($urandom_range(0, 9) == 0) pb = HdrLike[$urandom_range(0, 15)];
          else pb = 8'($urandom_range(0, 255));
          push_rx(pb, 1'b0, '0);
        end
      end
    end else if (r < 85) begin
      case ($urandom_range(0, 4))
        0: send_text({HdrText, ","});
        1: send_text({HdrText, lt, ",:"});
        2: begin
          send_text({HdrText, lt});
          push_rx(pick_stray(ChComma), 1'b0, '0);
        end
        3: begin
          send_text({HdrText, lt, ",", $sformatf("%0d", $urandom_range(0, 99))});
          push_rx(pick_stray(ChColon), 1'b0, '0);
        end
        default: send_text(HdrText.substr(0, $urandom_range(0, HdrLen - 2)));
      endcase
    end else begin
      repeat ($urandom_range(1, 12)) begin
        if ($urandom_range(0, 4) == 0) push_rx(ChPlus, 1'b0, '0);
        else push_rx(8'($urandom_range(0, 255)), 1'b0, '0);
      end
    end
  endtask

  function automatic void cmp_field(input string name, input int want, input int got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_outputs.size() == 0) begin
        errors++;
        $display("%0t: unexpected item, expected none, got kind=%0d byte=%02h link=%0d last=%0d",
                 $time, out_kind, out_payload_byte, out_link_number, out_is_last);
      end else begin
        head = pending_outputs.pop_front();
        cmp_field("kind", head.kind, out_kind);
        cmp_field("payload_byte", head.data, out_payload_byte);
        cmp_field("link_number", head.link, out_link_number);
        cmp_field("is_last", head.last, out_is_last);
        n_results++;
        if (head.kind == KindReject) n_rejects++;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= StallLimit) begin
      $display("%0t: watchdog expired, %0d items still pending", $time, pending_outputs.size());
      $display("end of test: mismatches");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int hold;
    hold = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        out_ready = 1'b0;
        hold--;
      end else if (!calm && $urandom_range(0, 2) == 0) begin
        out_ready = 1'b0;
        hold = pick_gap();
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  initial begin
    dir_row_t row;
    logic [10:0] phase_max;
    int phase_start;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_rx_byte = 8'h00;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    calm = 1'b0;
    errors = 0;
    n_items = 0;
    n_results = 0;
    n_rejects = 0;
    n_writes = 0;
    idle_cycles = 0;
    max_len = MaxLenReset;
    drop_header(8'h00);
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    add_text("++IPD,999,0");
    add_byte(ChColon, 1'b1, '{kind: KindReject, data: 8'h00, link: LinkSat, last: 1'b1});
    add_text("+IPD,3,2:");
    add_byte(8'h00, 1'b1, '{kind: KindData, data: 8'h00, link: 8'd3, last: 1'b0});
    add_byte(8'hFF, 1'b1, '{kind: KindData, data: 8'hFF, link: 8'd3, last: 1'b1});
    add_text("+IPD,5,:");
    add_text("+IPD,1x");
    add_cfg(AddrMaxLen, 32'd0);
    add_cfg(AddrSpare, 32'd100);
    add_text("+IPD,7,1");
    add_byte(ChColon, 1'b1, '{kind: KindReject, data: 8'h00, link: 8'd7, last: 1'b1});
    add_cfg(AddrMaxLen, 32'd2047);
    add_text("+IPD,1,99999");
    add_byte(ChColon, 1'b1, '{kind: KindReject, data: 8'h00, link: 8'd1, last: 1'b1});

    for (int i = 0; i < dir_rows.size(); i++) begin
      row = dir_rows[i];
      case (row.op)
        RowText: send_text(dir_texts[i]);
        RowByte: push_rx(row.b, row.fixed, row.evt);
        default: write_reg(row.addr, row.wdata);
      endcase
    end

    for (int p = 0; p < 8; p++) begin
      case (p)
        0: phase_max = 11'd1;
        1: phase_max = 11'd2047;
        2: phase_max = 11'($urandom_range(2, 64));
        3: phase_max = MaxLenReset;
        4: phase_max = 11'($urandom_range(1, 2047));
        5: phase_max = 11'd8;
        6: phase_max = 11'($urandom_range(1, 16));
        default: phase_max = 11'd2047;
      endcase
      write_reg(AddrMaxLen, {21'd0, phase_max});
      phase_start = n_items;
      while (n_items - phase_start < PhaseItems) begin
        calm = ($urandom_range(0, 9) == 0);
        send_segment();
      end
      calm = 1'b0;
    end

    @(negedge clk);
    in_valid = 1'b0;
    while (pending_outputs.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("fed %0d bytes over 8 length limits plus directed frames, %0d register writes",
             n_items, n_writes);
    $display("checked %0d results, %0d of them header rejects", n_results, n_rejects);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
